@@ hdl/hbp_pkg.sv @@
// Shared types and constants for the Huffman bit packer.
// Used by hbp_packer and huffman_bit_packer_unit; no dependencies.
`timescale 1ns / 1ps

package hbp_pkg;

  localparam int CodeW      = 64;
  localparam int LenW       = 7;
  localparam int SymW       = 8;
  localparam int ByteW      = 8;
  localparam int MaxCodeLen = 64;
  localparam int NumSymbols = 256;
  localparam int SymIdxW    = $clog2(NumSymbols);

  // Request function codes
  typedef enum logic [1:0] {
    FuncLoad   = 2'd0,
    FuncEncode = 2'd1,
    FuncFlush  = 2'd2,
    FuncNone   = 2'd3
  } hbp_func_e;

  // One table entry as held in the code memory
  typedef struct packed {
    logic [LenW-1:0]  len;
    logic [CodeW-1:0] code;
  } hbp_entry_t;

  // Start command from request decode to the packer
  typedef struct packed {
    logic encode;
    logic flush;
  } hbp_cmd_t;

endpackage

@@ hdl/hbp_code_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module hbp_code_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/hbp_packer.sv @@
// Bit accumulator and output byte register of the Huffman bit packer.
// Depends on hbp_pkg.
`timescale 1ns / 1ps

module hbp_packer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hbp_pkg::hbp_cmd_t  start_i,
  input  hbp_pkg::hbp_entry_t entry_i,
  output logic               idle_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [hbp_pkg::ByteW-1:0] out_byte_o,
  output logic               last_o
);

  typedef enum logic [2:0] {
    StIdle,
    StAlign,
    StPack,
    StFlushData,
    StFlushTrail
  } state_e;

  state_e                          state_q, state_d;
  logic [hbp_pkg::CodeW-1:0]       word_q, word_d;
  logic [hbp_pkg::LenW-1:0]        rem_q, rem_d;
  logic [hbp_pkg::ByteW-2:0]       pend_q, pend_d;
  logic [2:0]                      cnt_q, cnt_d;
  logic                            out_valid_q, out_valid_d;
  logic [hbp_pkg::ByteW-1:0]       out_byte_q, out_byte_d;
  logic                            out_last_q, out_last_d;

  logic                            out_free;
  logic [3:0]                      avail;
  logic [3:0]                      take;
  logic [3:0]                      fill;
  logic                            full;
  logic [hbp_pkg::ByteW-1:0]       rev;
  logic [hbp_pkg::ByteW-1:0]       shifted;
  logic [15:0]                     mask_w;
  logic [hbp_pkg::ByteW-1:0]       merged;
  logic [hbp_pkg::LenW-1:0]        rem_after;
  logic [hbp_pkg::ByteW-1:0]       trailer;

  // Merge the next code bits (MSB first) above the pending bits
  always_comb begin
    out_free = !out_valid_q || out_ready_i;
    avail    = 4'd8 - {1'b0, cnt_q};
    take     = (rem_q < hbp_pkg::LenW'(avail)) ? rem_q[3:0] : avail;
    for (int j = 0; j < hbp_pkg::ByteW; j++) begin
      rev[j] = word_q[hbp_pkg::CodeW-1-j];
    end
    shifted   = hbp_pkg::ByteW'(rev << cnt_q);
    mask_w    = ((16'd1 << take) - 16'd1) << cnt_q;
    merged    = {1'b0, pend_q} | (shifted & mask_w[hbp_pkg::ByteW-1:0]);
    fill      = {1'b0, cnt_q} + take;
    full      = (fill == 4'd8);
    rem_after = rem_q - hbp_pkg::LenW'(take);
    trailer   = (cnt_q == 3'd0) ? '0 : hbp_pkg::ByteW'(4'd8 - {1'b0, cnt_q});
  end

  // Next state
  always_comb begin
    state_d     = state_q;
    word_d      = word_q;
    rem_d       = rem_q;
    pend_d      = pend_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      StIdle: begin
        if (start_i.encode) begin
          state_d = StAlign;
        end else if (start_i.flush) begin
          state_d = (cnt_q != 3'd0) ? StFlushData : StFlushTrail;
        end
      end
      StAlign: begin
        // Left-align the code word so its first bit sits at the top
        word_d  = entry_i.code << (hbp_pkg::LenW'(hbp_pkg::CodeW) - entry_i.len);
        rem_d   = entry_i.len;
        state_d = StPack;
      end
      StPack: begin
        if (full) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_byte_d  = merged;
            out_last_d  = (rem_after < hbp_pkg::LenW'(hbp_pkg::ByteW));
            pend_d      = '0;
            cnt_d       = '0;
            word_d      = word_q << take;
            rem_d       = rem_after;
            state_d     = (rem_after == '0) ? StIdle : StPack;
          end
        end else begin
          // Leftover bits do not fill a byte: keep them pending
          pend_d  = merged[hbp_pkg::ByteW-2:0];
          cnt_d   = fill[2:0];
          rem_d   = '0;
          state_d = StIdle;
        end
      end
      StFlushData: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = {1'b0, pend_q};
          out_last_d  = 1'b0;
          state_d     = StFlushTrail;
        end
      end
      StFlushTrail: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = trailer;
          out_last_d  = 1'b1;
          pend_d      = '0;
          cnt_d       = '0;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // State and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rem_q       <= '0;
      pend_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      word_q      <= '0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      word_q      <= word_d;
      out_byte_q  <= out_byte_d;
      out_last_q  <= out_last_d;
    end
  end

  assign idle_o      = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = out_last_q;

endmodule

@@ hdl/huffman_bit_packer_unit.sv @@
// Huffman encoder back end: code table memory, request decode, bit packer.
// Depends on hbp_pkg, hbp_code_ram and hbp_packer.
//
// Usage
//   Input channel (in_valid_i / in_ready_o) carries requests: func_i selects
//   load (write symbol_i's code_bits_i / code_len_i into the table), encode
//   (append symbol_i's code to the bit stream) or flush (emit the partial
//   byte and a trailer byte with the unused-bit count, or a single zero).
//   Output channel (out_valid_o / out_ready_i) returns the bytes that a request
//   produces (none for a load), with last_o marking the final byte caused by a request.
//   A load only writes the table. An encode reads the table memory, then
//   aligns the code word, then packs one completed byte per step while the
//   output register is free, and keeps the leftover bits pending unless the
//   last code bit completes a byte. A flush emits the pending partial byte,
//   if any, then the trailer byte. One request is worked on at a time.
//   A stalled receiver holds the output register and the packer waits;
//   a request is taken while the last byte still sits in the output register.
//   Reset empties the bit accumulator and marks every table entry as having
//   zero length; code words read as don't-care until loaded.
`timescale 1ns / 1ps

module huffman_bit_packer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   func_i,
  input  logic [hbp_pkg::SymW-1:0]     symbol_i,
  input  logic [hbp_pkg::CodeW-1:0]    code_bits_i,
  input  logic [hbp_pkg::LenW-1:0]     code_len_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [hbp_pkg::ByteW-1:0]    out_byte_o,
  output logic                         last_o
);

  logic                         accept;
  logic                         in_range;
  logic [hbp_pkg::SymIdxW-1:0]  idx;
  logic [hbp_pkg::LenW-1:0]     len_sat;
  logic                         wr_en;
  logic                         rd_en;
  hbp_pkg::hbp_entry_t          wr_entry;
  logic [$bits(hbp_pkg::hbp_entry_t)-1:0] rd_data;
  hbp_pkg::hbp_entry_t          rd_entry;
  hbp_pkg::hbp_entry_t          lookup;
  hbp_pkg::hbp_cmd_t            cmd;
  logic                         pk_idle;

  logic [hbp_pkg::NumSymbols-1:0] valid_q;
  logic                           valid_rd_q;

  // Request decode
  always_comb begin
    accept   = in_valid_i && in_ready_o;
    in_range = ({1'b0, symbol_i} < (hbp_pkg::SymW + 1)'(hbp_pkg::NumSymbols));
    idx      = symbol_i[hbp_pkg::SymIdxW-1:0];
    len_sat  = (code_len_i > hbp_pkg::LenW'(hbp_pkg::MaxCodeLen))
               ? hbp_pkg::LenW'(hbp_pkg::MaxCodeLen) : code_len_i;
    wr_en    = accept && (func_i == hbp_pkg::FuncLoad) && in_range;
    rd_en    = accept && (func_i == hbp_pkg::FuncEncode);
    wr_entry.len  = len_sat;
    wr_entry.code = code_bits_i;
    cmd.encode = rd_en;
    cmd.flush  = accept && (func_i == hbp_pkg::FuncFlush);
  end

  // Code table memory
  hbp_code_ram #(
    .Width ($bits(hbp_pkg::hbp_entry_t)),
    .Depth (hbp_pkg::NumSymbols)
  ) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (idx),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (idx),
    .rdata_o (rd_data)
  );

  // Per-entry written flags; an unwritten entry reads as zero length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      valid_rd_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[idx] <= 1'b1;
      end
      if (rd_en) begin
        valid_rd_q <= in_range && valid_q[idx];
      end
    end
  end

  always_comb begin
    rd_entry    = rd_data;
    lookup.code = rd_entry.code;
    lookup.len  = valid_rd_q ? rd_entry.len : '0;
  end

  // Bit packer
  hbp_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd),
    .entry_i     (lookup),
    .idle_o      (pk_idle),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

  assign in_ready_o = pk_idle;

`ifndef SYNTHESIS
  // A flush always produces output, so the packer must go busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (func_i == hbp_pkg::FuncFlush) |=> !in_ready_o)
    else $error("flush request did not start the packer");

  // An encode waits for the table read before the next request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (func_i == hbp_pkg::FuncEncode) |=> !in_ready_o)
    else $error("encode request did not wait for the table read");

  // A load touches only the table and leaves the block ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (func_i == hbp_pkg::FuncLoad) |=> in_ready_o)
    else $error("load request stalled the block");
`endif

endmodule
